FILE: hw/rtl/cdec_pkg.sv
// ----------------------------------------------------------------------------
// cdec_pkg
// Shared types, field layout and fixed-point reciprocals for the civil date
// and epoch seconds converter.
// ----------------------------------------------------------------------------
package cdec_pkg;

  // pipeline depth, accept to result
  localparam int NUM_STAGES = 13;
  localparam int LAST       = NUM_STAGES - 1;

  // direction selector carried in tuser
  typedef enum logic {
    FUNC_TO_EPOCH = 1'b0,
    FUNC_TO_DATE  = 1'b1
  } func_t;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int EPOCH_W = 39;

  // bus widths, padded to whole bytes
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  // calendar offsets
  localparam int DAYS_TO_EPOCH = 719468;            // 0000-03-01 to 1970-01-01
  localparam int ERA_DAYS      = 146097;
  localparam int HI_BIAS       = 49;                // keeps the high half positive
  localparam int HI_BIAS_OFS   = 675 * HI_BIAS;
  localparam int ERA_BIAS      = 17;                // keeps the day count positive
  localparam int DD_BIAS       = DAYS_TO_EPOCH + ERA_BIAS * ERA_DAYS;

  // reciprocals: q = (n * rcp) >> sh, exact over each operand range
  localparam int SH_400 = 24;
  localparam logic [15:0] RCP_400 =
    16'(((64'd1 << SH_400) + 64'd399) / 64'd400);
  localparam int SH_675_HI = 27;
  localparam logic [17:0] RCP_675_HI =
    18'(((64'd1 << SH_675_HI) + 64'd674) / 64'd675);
  localparam int SH_675_LO = 36;
  localparam logic [26:0] RCP_675_LO =
    27'(((64'd1 << SH_675_LO) + 64'd674) / 64'd675);
  localparam int SH_60 = 23;
  localparam logic [17:0] RCP_60 =
    18'(((64'd1 << SH_60) + 64'd59) / 64'd60);
  localparam int SH_60_MIN = 17;
  localparam logic [11:0] RCP_60_MIN =
    12'(((64'd1 << SH_60_MIN) + 64'd59) / 64'd60);
  localparam int SH_ERA = 41;
  localparam logic [23:0] RCP_ERA =
    24'(((64'd1 << SH_ERA) + 64'd146096) / 64'd146097);
  localparam int SH_1460 = 29;
  localparam logic [18:0] RCP_1460 =
    19'(((64'd1 << SH_1460) + 64'd1459) / 64'd1460);
  localparam int SH_365 = 27;
  localparam logic [18:0] RCP_365 =
    19'(((64'd1 << SH_365) + 64'd364) / 64'd365);
  localparam int SH_153 = 19;
  localparam logic [11:0] RCP_153 =
    12'(((64'd1 << SH_153) + 64'd152) / 64'd153);

  // first day of month, counted from march: (153 * mp + 2) / 5
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      4'd12:   off = 9'd367;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // century count within an era
  function automatic logic [1:0] div100(input logic [8:0] yoe);
    logic [1:0] q;
    if (yoe >= 9'd300) begin
      q = 2'd3;
    end else if (yoe >= 9'd200) begin
      q = 2'd2;
    end else if (yoe >= 9'd100) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return q;
  endfunction

  // day of era divided by 36524
  function automatic logic [2:0] div36524(input logic [17:0] doe);
    logic [2:0] q;
    q = 3'(doe >= 18'd36524) + 3'(doe >= 18'd73048) +
        3'(doe >= 18'd109572) + 3'(doe >= 18'd146096);
    return q;
  endfunction

endpackage

FILE: hw/rtl/civil_date_epoch_converter.sv
// ----------------------------------------------------------------------------
// civil_date_epoch_converter
// Proleptic Gregorian date and time to Unix epoch seconds and back, using
// 400-year eras from march. Fully pipelined, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
// each item passes every stage register to out_tvalid, either direction
// throughput: one item per cycle; stages stall independently, so bubbles
//   are squeezed out and the input keeps taking items while a result waits,
//   until every stage holds an item
// depth is set by the chain of reciprocal multiplies of the date split
//   (seconds to days, days to era, day of era to year, day of year to month)
// reset clears the stage valid bits only; datapath registers are not reset
module civil_date_epoch_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28]
  // second[39:34] epoch[78:40] pad[79]
  input  logic [cdec_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // epoch[38:0] year[52:39] month[56:53] day[61:57] hour[66:62]
  // minute[72:67] second[78:73] pad[79]
  output logic [cdec_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import cdec_pkg::*;

  typedef struct packed {
    logic [EPOCH_W-1:0] ep;
    logic [HOUR_W-1:0]  hh;
    logic [MIN_W-1:0]   mi;
    logic [SEC_W-1:0]   ss;
  } carry_t;

  // stage control
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] fn_r;
  logic [NUM_STAGES-1:0] en;

  // input fields
  logic [YEAR_W-1:0]  i_year;
  logic [MONTH_W-1:0] i_month;
  logic [DAY_W-1:0]   i_day;
  logic [HOUR_W-1:0]  i_hour;
  logic [MIN_W-1:0]   i_minute;
  logic [SEC_W-1:0]   i_second;
  logic [EPOCH_W-1:0] i_epoch;

  assign i_year   = in_tdata[13:0];
  assign i_month  = in_tdata[17:14];
  assign i_day    = in_tdata[22:18];
  assign i_hour   = in_tdata[27:23];
  assign i_minute = in_tdata[33:28];
  assign i_second = in_tdata[39:34];
  assign i_epoch  = in_tdata[78:40];

  // a stage moves when any stage from it to the output is empty or drains
  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      en[k] = out_tready ||
              !(&(v_r | NUM_STAGES'((NUM_STAGES'(1) << k) - NUM_STAGES'(1))));
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fn_r[0] <= in_tuser;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        fn_r[k] <= fn_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: year bias, day of year, time of day; epoch split at 2^7
  // --------------------------------------------------------------------------
  logic              m_le2;
  logic [3:0]        mp0;
  logic [14:0]       s0_n_nxt,   s0_n_r;
  logic signed [9:0] s0_doy_nxt, s0_doy_r;
  logic [16:0]       s0_tod_nxt, s0_tod_r;
  logic [16:0]       s0_nh_nxt,  s0_nh_r;
  logic [15:0]       s0_al_r;
  logic [6:0]        s0_lo7_r;
  logic [15:0]       ah;

  always_comb begin
    m_le2      = (i_month <= 4'd2);
    mp0        = m_le2 ? (i_month + 4'd9) : (i_month - 4'd3);
    s0_n_nxt   = 15'(i_year) + 15'd400 - 15'(m_le2);
    s0_doy_nxt = $signed({1'b0, month_offset(mp0)}) + $signed({5'b0, i_day}) - 10'sd1;
    s0_tod_nxt = 17'(i_hour) * 17'd3600 + 17'(i_minute) * 17'd60 + 17'(i_second);
    ah         = i_epoch[38:23];
    s0_nh_nxt  = 17'($signed({ah[15], ah[15], ah}) + $signed(18'(HI_BIAS_OFS)));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_n_r   <= s0_n_nxt;
      s0_doy_r <= s0_doy_nxt;
      s0_tod_r <= s0_tod_nxt;
      s0_nh_r  <= s0_nh_nxt;
      s0_al_r  <= i_epoch[22:7];
      s0_lo7_r <= i_epoch[6:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: era quotient by 400; high half quotient by 675
  // --------------------------------------------------------------------------
  logic [30:0]       p400;
  logic [34:0]       phi;
  logic [5:0]        s1_q_nxt, s1_q_r;
  logic [6:0]        s1_qhp_nxt, s1_qhp_r;
  logic [14:0]       s1_n_r;
  logic signed [9:0] s1_doy_r;
  logic [16:0]       s1_tod_r;
  logic [16:0]       s1_nh_r;
  logic [15:0]       s1_al_r;
  logic [6:0]        s1_lo7_r;

  always_comb begin
    p400       = 31'(s0_n_r) * 31'(RCP_400);
    s1_q_nxt   = 6'(p400 >> SH_400);
    phi        = 35'(s0_nh_r) * 35'(RCP_675_HI);
    s1_qhp_nxt = 7'(phi >> SH_675_HI);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_q_r   <= s1_q_nxt;
      s1_qhp_r <= s1_qhp_nxt;
      s1_n_r   <= s0_n_r;
      s1_doy_r <= s0_doy_r;
      s1_tod_r <= s0_tod_r;
      s1_nh_r  <= s0_nh_r;
      s1_al_r  <= s0_al_r;
      s1_lo7_r <= s0_lo7_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: year of era; remainder of high half joined with low half
  // --------------------------------------------------------------------------
  logic [8:0]        s2_yoe_nxt, s2_yoe_r;
  logic signed [6:0] s2_era_nxt, s2_era_r;
  logic [9:0]        rh;
  logic [25:0]       s2_t_nxt, s2_t_r;
  logic signed [7:0] s2_qh_nxt, s2_qh_r;
  logic signed [9:0] s2_doy_r;
  logic [16:0]       s2_tod_r;
  logic [6:0]        s2_lo7_r;

  always_comb begin
    s2_yoe_nxt = 9'(15'(s1_n_r) - 15'(s1_q_r) * 15'd400);
    s2_era_nxt = $signed({1'b0, s1_q_r}) - 7'sd1;
    rh         = 10'(s1_nh_r - 17'(s1_qhp_r) * 17'd675);
    s2_t_nxt   = {rh, s1_al_r};
    s2_qh_nxt  = $signed({1'b0, s1_qhp_r}) - $signed(8'(HI_BIAS));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_yoe_r <= s2_yoe_nxt;
      s2_era_r <= s2_era_nxt;
      s2_t_r   <= s2_t_nxt;
      s2_qh_r  <= s2_qh_nxt;
      s2_doy_r <= s1_doy_r;
      s2_tod_r <= s1_tod_r;
      s2_lo7_r <= s1_lo7_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: day of era; low quotient by 675
  // --------------------------------------------------------------------------
  logic [17:0]        doe_base;
  logic signed [18:0] s3_doe_nxt, s3_doe_r;
  logic [52:0]        plo;
  logic [15:0]        s3_qt_nxt, s3_qt_r;
  logic signed [6:0]  s3_era_r;
  logic [16:0]        s3_tod_r;
  logic [25:0]        s3_t_r;
  logic signed [7:0]  s3_qh_r;
  logic [6:0]         s3_lo7_r;

  always_comb begin
    doe_base   = 18'(s2_yoe_r) * 18'd365 + 18'(s2_yoe_r >> 2) - 18'(div100(s2_yoe_r));
    s3_doe_nxt = $signed({1'b0, doe_base}) + $signed({{9{s2_doy_r[9]}}, s2_doy_r});
    plo        = 53'(s2_t_r) * 53'(RCP_675_LO);
    s3_qt_nxt  = 16'(plo >> SH_675_LO);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_doe_r <= s3_doe_nxt;
      s3_qt_r  <= s3_qt_nxt;
      s3_era_r <= s2_era_r;
      s3_tod_r <= s2_tod_r;
      s3_t_r   <= s2_t_r;
      s3_qh_r  <= s2_qh_r;
      s3_lo7_r <= s2_lo7_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: day number from date; floor day number and second of day
  // --------------------------------------------------------------------------
  logic signed [24:0] s4_days0_nxt, s4_days0_r;
  logic [9:0]         rem;
  logic [16:0]        s4_sod_nxt, s4_sod_r;
  logic signed [23:0] s4_days1_r;
  logic [16:0]        s4_tod_r;

  always_comb begin
    s4_days0_nxt = $signed({{18{s3_era_r[6]}}, s3_era_r}) * $signed(25'(ERA_DAYS)) +
                   $signed({{6{s3_doe_r[18]}}, s3_doe_r}) - $signed(25'(DAYS_TO_EPOCH));
    rem          = 10'(s3_t_r - 26'(s3_qt_r) * 26'd675);
    s4_sod_nxt   = {rem, s3_lo7_r};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_days0_r <= s4_days0_nxt;
      s4_sod_r   <= s4_sod_nxt;
      s4_days1_r <= {s3_qh_r, s3_qt_r};
      s4_tod_r   <= s3_tod_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: epoch seconds; biased day count; minutes of day
  // --------------------------------------------------------------------------
  logic signed [41:0] ep_full;
  logic [34:0]        p60;
  logic [22:0]        s5_dd_nxt, s5_dd_r;
  logic [10:0]        s5_q60_nxt, s5_q60_r;
  logic [16:0]        s5_sod_r;
  carry_t             s5_c_nxt, s5_c_r;

  always_comb begin
    ep_full     = $signed({{17{s4_days0_r[24]}}, s4_days0_r}) * 42'sd86400 +
                  $signed({25'b0, s4_tod_r});
    s5_c_nxt    = '0;
    s5_c_nxt.ep = ep_full[EPOCH_W-1:0];
    s5_dd_nxt   = 23'($signed({s4_days1_r[23], s4_days1_r}) + $signed(25'(DD_BIAS)));
    p60         = 35'(s4_sod_r) * 35'(RCP_60);
    s5_q60_nxt  = 11'(p60 >> SH_60);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_c_r   <= s5_c_nxt;
      s5_dd_r  <= s5_dd_nxt;
      s5_q60_r <= s5_q60_nxt;
      s5_sod_r <= s4_sod_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: era quotient; hour and second
  // --------------------------------------------------------------------------
  logic [46:0] pera;
  logic [22:0] phr;
  logic [5:0]  s6_erap_nxt, s6_erap_r;
  logic [22:0] s6_dd_r;
  logic [10:0] s6_q60_r;
  carry_t      s6_c_nxt, s6_c_r;

  always_comb begin
    pera        = 47'(s5_dd_r) * 47'(RCP_ERA);
    s6_erap_nxt = 6'(pera >> SH_ERA);
    phr         = 23'(s5_q60_r) * 23'(RCP_60_MIN);
    s6_c_nxt    = s5_c_r;
    s6_c_nxt.hh = 5'(phr >> SH_60_MIN);
    s6_c_nxt.ss = 6'(s5_sod_r - 17'(s5_q60_r) * 17'd60);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_erap_r <= s6_erap_nxt;
      s6_dd_r   <= s5_dd_r;
      s6_q60_r  <= s5_q60_r;
      s6_c_r    <= s6_c_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: day of era, signed era; minute
  // --------------------------------------------------------------------------
  logic [17:0]       s7_doe_nxt, s7_doe_r;
  logic signed [6:0] s7_era_nxt, s7_era_r;
  carry_t            s7_c_nxt, s7_c_r;

  always_comb begin
    s7_doe_nxt  = 18'(s6_dd_r - 23'(s6_erap_r) * 23'(ERA_DAYS));
    s7_era_nxt  = $signed({1'b0, s6_erap_r}) - $signed(7'(ERA_BIAS));
    s7_c_nxt    = s6_c_r;
    s7_c_nxt.mi = 6'(s6_q60_r - 11'(s6_c_r.hh) * 11'd60);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_doe_r <= s7_doe_nxt;
      s7_era_r <= s7_era_nxt;
      s7_c_r   <= s7_c_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: leap-corrected day of era
  // --------------------------------------------------------------------------
  logic [36:0]       p1460;
  logic [6:0]        d1460;
  logic [17:0]       s8_v_nxt, s8_v_r;
  logic [17:0]       s8_doe_r;
  logic signed [6:0] s8_era_r;
  carry_t            s8_c_r;

  always_comb begin
    p1460    = 37'(s7_doe_r) * 37'(RCP_1460);
    d1460    = 7'(p1460 >> SH_1460);
    s8_v_nxt = s7_doe_r - 18'(d1460) + 18'(div36524(s7_doe_r)) -
               18'(s7_doe_r == 18'd146096);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_v_r   <= s8_v_nxt;
      s8_doe_r <= s7_doe_r;
      s8_era_r <= s7_era_r;
      s8_c_r   <= s7_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: year of era
  // --------------------------------------------------------------------------
  logic [36:0]       p365;
  logic [8:0]        s9_yoe_nxt, s9_yoe_r;
  logic [17:0]       s9_doe_r;
  logic signed [6:0] s9_era_r;
  carry_t            s9_c_r;

  always_comb begin
    p365       = 37'(s8_v_r) * 37'(RCP_365);
    s9_yoe_nxt = 9'(p365 >> SH_365);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_yoe_r <= s9_yoe_nxt;
      s9_doe_r <= s8_doe_r;
      s9_era_r <= s8_era_r;
      s9_c_r   <= s8_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: day of year and march-based year
  // --------------------------------------------------------------------------
  logic [8:0]         s10_doy_nxt, s10_doy_r;
  logic signed [14:0] s10_y_nxt, s10_y_r;
  carry_t             s10_c_r;

  always_comb begin
    s10_doy_nxt = 9'(s9_doe_r - (18'(s9_yoe_r) * 18'd365 + 18'(s9_yoe_r >> 2) -
                                 18'(div100(s9_yoe_r))));
    s10_y_nxt   = $signed({{8{s9_era_r[6]}}, s9_era_r}) * 15'sd400 +
                  $signed({6'b0, s9_yoe_r});
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_doy_r <= s10_doy_nxt;
      s10_y_r   <= s10_y_nxt;
      s10_c_r   <= s9_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 11: month counted from march
  // --------------------------------------------------------------------------
  logic [10:0]        mp_num;
  logic [22:0]        p153;
  logic [3:0]         s11_mp_nxt, s11_mp_r;
  logic [8:0]         s11_doy_r;
  logic signed [14:0] s11_y_r;
  carry_t             s11_c_r;

  always_comb begin
    mp_num     = 11'(s10_doy_r) * 11'd5 + 11'd2;
    p153       = 23'(mp_num) * 23'(RCP_153);
    s11_mp_nxt = 4'(p153 >> SH_153);
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_mp_r  <= s11_mp_nxt;
      s11_doy_r <= s10_doy_r;
      s11_y_r   <= s10_y_r;
      s11_c_r   <= s10_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 12: output register, calendar month and day, unused fields zeroed
  // --------------------------------------------------------------------------
  logic [MONTH_W-1:0] cal_month;
  logic [DAY_W-1:0]   cal_day;
  logic [YEAR_W-1:0]  cal_year;
  logic [EPOCH_W-1:0] s12_epoch_nxt, s12_epoch_r;
  logic [YEAR_W-1:0]  s12_year_nxt,  s12_year_r;
  logic [MONTH_W-1:0] s12_month_nxt, s12_month_r;
  logic [DAY_W-1:0]   s12_day_nxt,   s12_day_r;
  logic [HOUR_W-1:0]  s12_hour_nxt,  s12_hour_r;
  logic [MIN_W-1:0]   s12_min_nxt,   s12_min_r;
  logic [SEC_W-1:0]   s12_sec_nxt,   s12_sec_r;

  always_comb begin
    cal_month = (s11_mp_r < 4'd10) ? (s11_mp_r + 4'd3) : (s11_mp_r - 4'd9);
    cal_day   = 5'(s11_doy_r - month_offset(s11_mp_r) + 9'd1);
    cal_year  = 14'(s11_y_r + $signed({14'b0, (cal_month <= 4'd2)}));
    if (fn_r[LAST-1] == FUNC_TO_DATE) begin
      s12_epoch_nxt = '0;
      s12_year_nxt  = cal_year;
      s12_month_nxt = cal_month;
      s12_day_nxt   = cal_day;
      s12_hour_nxt  = s11_c_r.hh;
      s12_min_nxt   = s11_c_r.mi;
      s12_sec_nxt   = s11_c_r.ss;
    end else begin
      s12_epoch_nxt = s11_c_r.ep;
      s12_year_nxt  = '0;
      s12_month_nxt = '0;
      s12_day_nxt   = '0;
      s12_hour_nxt  = '0;
      s12_min_nxt   = '0;
      s12_sec_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      s12_epoch_r <= s12_epoch_nxt;
      s12_year_r  <= s12_year_nxt;
      s12_month_r <= s12_month_nxt;
      s12_day_r   <= s12_day_nxt;
      s12_hour_r  <= s12_hour_nxt;
      s12_min_r   <= s12_min_nxt;
      s12_sec_r   <= s12_sec_nxt;
    end
  end

  assign out_tdata = {1'b0, s12_sec_r, s12_min_r, s12_hour_r, s12_day_r,
                      s12_month_r, s12_year_r, s12_epoch_r};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // an item in the stage before the output moves on when the output loads
  a_last_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST-1] && en[LAST] |=> v_r[LAST])
    else $error("item lost entering output stage");

  // second of day stays inside one day
  a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (s4_sod_r < 17'd86400))
    else $error("second of day out of range");

  // epoch field is zero for date results
  a_date_no_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (fn_r[LAST] == FUNC_TO_DATE) |-> (s12_epoch_r == '0))
    else $error("epoch field set on date result");

  // date fields are zero for epoch results
  a_epoch_no_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (fn_r[LAST] == FUNC_TO_EPOCH) |->
      (s12_year_r == '0) && (s12_month_r == '0) && (s12_day_r == '0) &&
      (s12_hour_r == '0) && (s12_min_r == '0) && (s12_sec_r == '0))
    else $error("date field set on epoch result");

  // converted month is a real month
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (fn_r[LAST] == FUNC_TO_DATE) |->
      (s12_month_r >= 4'd1) && (s12_month_r <= 4'd12))
    else $error("month out of range");

endmodule
